// ===== hdl/slt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list table package
// Shared request and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control handed from the table controller to every cell
    typedef struct packed {
        logic insert;       // load the new value or take the left neighbour
        logic remove_shift; // take the right neighbour
        logic occupied;     // this cell lies below the entry count
    } t_cell_ctrl;

endpackage : slt_pkg
`default_nettype wire

// ===== hdl/slt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list table cell
// One table entry with its own compare against the value being inserted.
// ----------------------------------------------------------------------------
module slt_cell (
    input  wire logic                          i_clk,
    input  wire slt_pkg::t_cell_ctrl           i_ctrl,
    input  wire logic signed [31:0]            i_value,
    input  wire logic signed [31:0]            i_left_data,
    input  wire logic                          i_left_ge,
    input  wire logic signed [31:0]            i_right_data,
    output logic signed [31:0]                 o_data,
    output logic                               o_ge
);
    import slt_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    // An empty cell counts as greater, so the flag stays monotone along the row
    assign o_ge   = !i_ctrl.occupied || (r_data >= i_value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.insert) begin
            if (i_left_ge) begin
                n_data = i_left_data;
            end else if (o_ge) begin
                n_data = i_value;
            end
        end else if (i_ctrl.remove_shift) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule : slt_cell
`default_nettype wire

// ===== hdl/sorted_list_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list table
// Bounded table of signed values kept in ascending order, built as a row of
// entry cells that compare and shift in parallel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_req_type, i_value, i_index
//  response  out        o_out_valid / i_out_ready  o_read_value, o_status, o_count
//
//  The cell row updates at the edge that accepts a request, and the response
//  is loaded into the output register at that same edge.
//  One request per cycle is sustained while responses are taken; the output
//  register stalls the request side only while a response waits.
//  Reset clears the entry count; cell contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_list_table #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_req_type,
    input  wire logic signed [31:0]  i_value,
    input  wire logic [3:0]          i_index,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [31:0]       o_read_value,
    output logic [1:0]               o_status,
    output logic [4:0]               o_count
);
    import slt_pkg::*;

    // Count must hold CAPACITY itself
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    // Width wide enough for both the request index and the count
    localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_read_value;
    logic signed [DATA_W-1:0] n_read_value;
    t_status                  r_status;
    t_status                  n_status;

    logic                     accept;
    t_req                     req;
    logic                     full;
    logic                     in_range;
    logic                     do_insert;
    logic                     do_remove;

    t_cell_ctrl               cell_ctrl  [CAPACITY];
    logic signed [DATA_W-1:0] cell_data  [CAPACITY];
    logic                     cell_ge    [CAPACITY];
    logic signed [DATA_W-1:0] read_terms [CAPACITY];

    // Accept whenever the response register is free or draining this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign req        = t_req'(i_req_type);

    assign full      = (r_count == CW'(CAPACITY));
    assign in_range  = (IW'(i_index) < IW'(r_count));
    assign do_insert = accept && (req == REQ_INSERT) && !full;
    assign do_remove = accept && (req == REQ_REMOVE) && in_range;

    // Cell row: each cell takes its left neighbour on insert and its right
    // neighbour on remove; compare flags ripple left to right one hop only.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_ctrl[g].insert       = do_insert;
        assign cell_ctrl[g].remove_shift = do_remove && (IW'(g) >= IW'(i_index));
        assign cell_ctrl[g].occupied     = (CW'(g) < r_count);

        slt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl[g]),
            .i_value      (i_value),
            .i_left_data  ((g == 0) ? i_value : cell_data[(g == 0) ? 0 : g - 1]),
            .i_left_ge    ((g == 0) ? 1'b0 : cell_ge[(g == 0) ? 0 : g - 1]),
            .i_right_data ((g == CAPACITY - 1) ? cell_data[g]
                                               : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data       (cell_data[g]),
            .o_ge         (cell_ge[g])
        );

        // Read tap: each cell drives its value only when addressed
        assign read_terms[g] = (IW'(g) == IW'(i_index)) ? cell_data[g] : '0;
    end

    // Work out the response and the new count
    always_comb begin
        n_count      = r_count;
        n_status     = ST_OK;
        n_read_value = '0;
        case (req)
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_READ: begin
                if (in_range) begin
                    for (int k = 0; k < CAPACITY; k++) begin
                        n_read_value = n_read_value | read_terms[k];
                    end
                end else begin
                    n_status = ST_RANGE;
                end
            end
            REQ_REMOVE: begin
                if (in_range) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Hold the count and the response register; advance on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = 5'(r_count);

`ifndef ASSERT_OFF
    // Count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // A successful insert grows the table by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance count");

    // A full response reports a full table and no data
    a_full_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |->
            ((o_count == 5'(CAPACITY)) && (o_read_value == '0)))
        else $error("full response inconsistent");

    // The two smallest entries stay in order
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (cell_data[0] <= cell_data[1]))
        else $error("table head out of order");
`endif

endmodule : sorted_list_table
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table testbench
// Drives insert, read, remove and clear transactions with random gaps and
// response stalls, predicts every response from a model of the ordered table
// and checks each one field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import slt_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;

    typedef struct {
        logic signed [31:0] read_value;
        t_status            status;
        logic [4:0]         count;
    } t_table_response;

    // Holds a shadow of the table and the queue of responses still owed.
    class table_scoreboard;
        logic signed [31:0] cells [TABLE_DEPTH];
        int unsigned        fill;
        t_table_response    owed [$];
        int                 mismatches;
        int                 responses_seen;
        int                 kind_seen [4];
        int                 full_drops;
        int                 range_misses;
        int unsigned        peak_fill;

        function new();
            fill = 0;
            mismatches = 0;
            responses_seen = 0;
            full_drops = 0;
            range_misses = 0;
            peak_fill = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        // Apply one accepted request to the shadow table and queue its response.
        function void note_request(t_req kind, logic signed [31:0] val, logic [3:0] idx);
            t_table_response r;
            int unsigned     pos;
            int              i;
            r.read_value = '0;
            r.status     = ST_OK;
            kind_seen[kind]++;
            case (kind)
                REQ_INSERT: begin
                    if (fill >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                        full_drops++;
                    end else begin
                        // New value goes in front of the first entry not below it
                        pos = fill;
                        for (i = 0; i < int'(fill); i++) begin
                            if (cells[i] >= val) begin
                                pos = i;
                                break;
                            end
                        end
                        for (i = int'(fill); i > int'(pos); i--) cells[i] = cells[i-1];
                        cells[pos] = val;
                        fill++;
                    end
                end
                REQ_READ: begin
                    if (idx < fill) begin
                        r.read_value = cells[idx];
                    end else begin
                        r.status = ST_RANGE;
                        range_misses++;
                    end
                end
                REQ_REMOVE: begin
                    if (idx < fill) begin
                        for (i = idx; i + 1 < int'(fill); i++) cells[i] = cells[i+1];
                        fill--;
                    end else begin
                        r.status = ST_RANGE;
                        range_misses++;
                    end
                end
                default: begin
                    fill = 0;
                end
            endcase
            if (fill > peak_fill) peak_fill = fill;
            r.count = fill[4:0];
            owed.push_back(r);
        endfunction

        // Compare one accepted response against the oldest one owed.
        function void check_response(logic signed [31:0] rd, logic [1:0] st, logic [4:0] cnt);
            t_table_response e;
            responses_seen++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected response: read_value=%0d status=%0d count=%0d",
                             $realtime, rd, st, cnt);
                return;
            end
            e = owed.pop_front();
            if (rd !== e.read_value || st !== e.status || cnt !== e.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] response %0d: expected value=%0d status=%0d count=%0d, got value=%0d status=%0d count=%0d",
                             $realtime, responses_seen, e.read_value, e.status, e.count,
                             rd, st, cnt);
            end
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction
    endclass

    localparam int unsigned RANDOM_ITEMS = 1650;

    // Traffic mixes for the random phases
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    logic               out_ready   = 1'b0;
    logic [1:0]         req_type    = '0;
    logic signed [31:0] req_value   = '0;
    logic [3:0]         req_index   = '0;
    logic               in_ready;
    logic               out_valid;
    logic signed [31:0] rsp_value;
    logic [1:0]         rsp_status;
    logic [4:0]         rsp_count;

    table_scoreboard sb = new();
    int              random_sent = 0;
    bit              busy_phase = 1'b1;

    sorted_list_table #(
        .CAPACITY(TABLE_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_req_type  (req_type),
        .i_value     (req_value),
        .i_index     (req_index),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_read_value(rsp_value),
        .o_status    (rsp_status),
        .o_count     (rsp_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watch both channels; a response can never belong to a request taken at
    // the same edge, so check before noting.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) sb.check_response(rsp_value, rsp_status, rsp_count);
            if (in_valid && in_ready) sb.note_request(t_req'(req_type), req_value, req_index);
        end
    end

    // Response side: bursts of ready broken by stalls, mostly short
    initial begin
        int burst;
        int stall;
        forever begin
            case ($urandom_range(0, 9))
                0:       burst = $urandom_range(100, 300);
                1, 2, 3: burst = $urandom_range(9, 40);
                default: burst = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 49))
                0:                   stall = $urandom_range(30, 60);
                1, 2, 3, 4:          stall = $urandom_range(6, 15);
                5, 6, 7, 8, 9, 10,
                11, 12, 13, 14, 15,
                16, 17, 18, 19, 20,
                21:                  stall = $urandom_range(2, 5);
                default:             stall = 1;
            endcase
            repeat (burst) begin
                out_ready <= 1'b1;
                @(posedge i_clk);
            end
            repeat (stall) begin
                out_ready <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    function automatic int gap_cycles();
        int r;
        if (!busy_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Values lean towards extremes, small repeats and copies of stored entries
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
            4, 5: begin
                if (sb.fill != 0) return sb.cells[$urandom_range(0, sb.fill - 1)];
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_index();
        if (sb.fill != 0 && $urandom_range(0, 9) < 8)
            return 4'($urandom_range(0, sb.fill - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic t_req pick_kind(int mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return REQ_CLEAR;
        case (mix)
            MIX_FILL:  return (r < 68) ? REQ_INSERT : (r < 88) ? REQ_READ : REQ_REMOVE;
            MIX_DRAIN: return (r < 18) ? REQ_INSERT : (r < 43) ? REQ_READ : REQ_REMOVE;
            default:   return (r < 42) ? REQ_INSERT : (r < 72) ? REQ_READ : REQ_REMOVE;
        endcase
    endfunction

    // Present one transaction after an optional idle gap and hold it until
    // taken. Entered and left just after a rising edge.
    task automatic send_request(t_req kind, logic signed [31:0] val, logic [3:0] idx);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_type  <= kind;
        req_value <= val;
        req_index <= idx;
        in_valid  <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    initial begin
        int phase_len;
        int mix;
        int n;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: every access misses, clear is harmless
        send_request(REQ_READ, 32'sd0, 4'd0);
        send_request(REQ_REMOVE, 32'sd0, 4'd0);
        send_request(REQ_CLEAR, 32'sd0, 4'd0);
        // Extremes and a duplicate that must land in front of its twin
        send_request(REQ_INSERT, 32'sh7FFF_FFFF, 4'd0);
        send_request(REQ_INSERT, 32'sh8000_0000, 4'd0);
        send_request(REQ_INSERT, 32'sd0, 4'd0);
        send_request(REQ_INSERT, -32'sd1, 4'd0);
        send_request(REQ_INSERT, 32'sd0, 4'd0);
        send_request(REQ_INSERT, 32'sh5555_5555, 4'd0);
        send_request(REQ_INSERT, 32'shAAAA_AAAA, 4'd0);
        send_request(REQ_READ, 32'sd0, 4'd0);
        send_request(REQ_READ, 32'sd0, 4'd3);
        send_request(REQ_READ, 32'sd0, 4'd6);
        // Index equal to the count, then the top index
        send_request(REQ_READ, 32'sd0, 4'd7);
        send_request(REQ_READ, 32'sd0, 4'd15);
        send_request(REQ_REMOVE, 32'sd0, 4'd15);
        send_request(REQ_REMOVE, 32'sd0, 4'd6);
        send_request(REQ_REMOVE, 32'sd0, 4'd0);
        send_request(REQ_REMOVE, 32'sd0, 4'd2);
        send_request(REQ_READ, 32'sd0, 4'd1);
        send_request(REQ_CLEAR, 32'sd0, 4'd0);
        send_request(REQ_READ, 32'sd0, 4'd0);

        // Random phases: filling runs drive the table into its full state,
        // draining runs empty it; some phases run back to back with no gaps
        while (random_sent < RANDOM_ITEMS) begin
            phase_len  = $urandom_range(20, 80);
            mix        = $urandom_range(MIX_FILL, MIX_EVEN);
            busy_phase = ($urandom_range(0, 3) != 0);
            for (n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
                case (pick_kind(mix))
                    REQ_INSERT: send_request(REQ_INSERT, pick_value(), 4'($urandom));
                    REQ_READ:   send_request(REQ_READ, $urandom, pick_index());
                    REQ_REMOVE: send_request(REQ_REMOVE, $urandom, pick_index());
                    default:    send_request(REQ_CLEAR, $urandom, 4'($urandom));
                endcase
                random_sent++;
            end
        end
        in_valid <= 1'b0;
        // Let the monitor note the last transaction before counting what is owed
        @(posedge i_clk);

        // Drain what is still owed, then watch a little longer for strays
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d transactions: %0d inserts, %0d reads, %0d removes, %0d clears",
                 sb.responses_seen, sb.kind_seen[REQ_INSERT], sb.kind_seen[REQ_READ],
                 sb.kind_seen[REQ_REMOVE], sb.kind_seen[REQ_CLEAR]);
        $display("Full-table drops %0d, out-of-range accesses %0d, peak fill %0d, mismatches %0d",
                 sb.full_drops, sb.range_misses, sb.peak_fill, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2000000;
        $display("Timeout with %0d responses outstanding", sb.outstanding());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/slt_pkg.sv
hdl/slt_cell.sv
hdl/sorted_list_table.sv
bench/tb_top.sv
